/* rtl/dqvs_pkg.sv */
package dqvs_pkg;

    localparam int WORD_W = 32;

    // request codes
    localparam logic [2:0] KIND_PUSH_FRONT = 3'd0;
    localparam logic [2:0] KIND_PUSH_BACK  = 3'd1;
    localparam logic [2:0] KIND_POP_FRONT  = 3'd2;
    localparam logic [2:0] KIND_POP_BACK   = 3'd3;
    localparam logic [2:0] KIND_SEARCH     = 3'd4;

    // result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_EMPTY    = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    typedef struct packed {
        logic [2:0]               kind;
        logic signed [WORD_W-1:0] value;
    } t_in;

    typedef struct packed {
        logic [1:0]               status;
        logic signed [WORD_W-1:0] popped_value;
        logic [4:0]               found_position;
        logic [4:0]               occupancy;
    } t_out;

endpackage

/* rtl/dqvs_ram.sv */
module dqvs_ram
    import dqvs_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [AW-1:0]            i_wr_addr,
    input  logic signed [WORD_W-1:0] i_wr_data,
    input  logic                     i_rd_en,
    input  logic [AW-1:0]            i_rd_addr,
    output logic signed [WORD_W-1:0] o_rd_data
);

    logic signed [WORD_W-1:0] r_mem [DEPTH];
    logic signed [WORD_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* rtl/deque_with_value_search_unit.sv */
// double-ended queue of signed 32-bit words with a value search
//
// input channel (i_valid / o_ready / i_data) takes one request item: push
// front, push back, pop front, pop back or search. output channel
// (o_valid / i_ready / o_data) returns exactly one result item per request.
// the words sit in a single-port-write, one-read ring memory with a registered
// read port; front index and count live in flip-flops.
//
// pushes and unused codes go straight to the result state, pops pass through
// a read state, and a search reads entries from the front one after another
// until a match or the last entry. one item is in flight at a time and
// o_ready is high only while the controller is idle, so a new item is taken
// only once the last one has moved its result to the output register.
//
// results go to an output register, so a stalled receiver holds o_data
// steady while the next item is already accepted and worked on; a second
// finished result waits until the register frees up.
//
// reset (synchronous, active low) empties the queue and drops any result;
// memory contents are left as they are and never used before being written.
module deque_with_value_search_unit
    import dqvs_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_in  i_data,
    output logic o_valid,
    input  logic i_ready,
    output t_out o_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP,
        S_SEARCH,
        S_DONE
    } t_state;

    t_state                   r_state, n_state;
    logic [AW-1:0]            r_front, n_front;
    logic [CW-1:0]            r_count, n_count;
    logic [CW-1:0]            r_idx, n_idx;
    logic [AW-1:0]            r_scan, n_scan;
    logic signed [WORD_W-1:0] r_key, n_key;
    logic [1:0]               r_status, n_status;
    logic signed [WORD_W-1:0] r_popped, n_popped;
    logic [4:0]               r_pos, n_pos;
    logic                     r_out_valid, n_out_valid;
    t_out                     r_out, n_out;

    // memory port
    logic                     mem_we;
    logic [AW-1:0]            mem_waddr;
    logic                     mem_re;
    logic [AW-1:0]            mem_raddr;
    logic signed [WORD_W-1:0] mem_rdata;

    // ring arithmetic
    logic [AW-1:0] front_inc;
    logic [AW-1:0] front_dec;
    logic [AW-1:0] scan_inc;
    logic [AW-1:0] slot_back;
    logic [AW-1:0] slot_last;
    logic [SW-1:0] sum_back;
    logic [SW-1:0] sum_last;
    logic          is_full;
    logic          is_empty;
    logic [CW-1:0] idx_inc;

    dqvs_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (mem_we),
        .i_wr_addr (mem_waddr),
        .i_wr_data (i_data.value),
        .i_rd_en   (mem_re),
        .i_rd_addr (mem_raddr),
        .o_rd_data (mem_rdata)
    );

    always_comb begin
        front_inc = (r_front == AW'(DEPTH - 1)) ? '0 : r_front + 1'b1;
        front_dec = (r_front == '0) ? AW'(DEPTH - 1) : r_front - 1'b1;
        scan_inc  = (r_scan == AW'(DEPTH - 1)) ? '0 : r_scan + 1'b1;

        // slot of the word just past the back, and of the back word
        sum_back = SW'(r_front) + SW'(r_count);
        if (sum_back >= SW'(DEPTH)) begin
            sum_back = sum_back - SW'(DEPTH);
        end
        slot_back = AW'(sum_back);

        sum_last = SW'(r_front) + SW'(r_count) - 1'b1;
        if (sum_last >= SW'(DEPTH)) begin
            sum_last = sum_last - SW'(DEPTH);
        end
        slot_last = AW'(sum_last);

        is_full  = (r_count == CW'(DEPTH));
        is_empty = (r_count == '0);
        idx_inc  = r_idx + 1'b1;
    end

    always_comb begin
        n_state     = r_state;
        n_front     = r_front;
        n_count     = r_count;
        n_idx       = r_idx;
        n_scan      = r_scan;
        n_key       = r_key;
        n_status    = r_status;
        n_popped    = r_popped;
        n_pos       = r_pos;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        mem_we      = 1'b0;
        mem_waddr   = slot_back;
        mem_re      = 1'b0;
        mem_raddr   = r_front;

        // receiver took the item
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_status = ST_OK;
                    n_popped = '0;
                    n_pos    = '0;
                    n_state  = S_DONE;
                    case (i_data.kind)
                        KIND_PUSH_FRONT: begin
                            if (is_full) begin
                                n_status = ST_FULL;
                            end else begin
                                mem_we    = 1'b1;
                                mem_waddr = front_dec;
                                n_front   = front_dec;
                                n_count   = r_count + 1'b1;
                            end
                        end
                        KIND_PUSH_BACK: begin
                            if (is_full) begin
                                n_status = ST_FULL;
                            end else begin
                                mem_we    = 1'b1;
                                mem_waddr = slot_back;
                                n_count   = r_count + 1'b1;
                            end
                        end
                        KIND_POP_FRONT: begin
                            if (is_empty) begin
                                n_status = ST_EMPTY;
                            end else begin
                                mem_re    = 1'b1;
                                mem_raddr = r_front;
                                n_front   = front_inc;
                                n_count   = r_count - 1'b1;
                                n_state   = S_POP;
                            end
                        end
                        KIND_POP_BACK: begin
                            if (is_empty) begin
                                n_status = ST_EMPTY;
                            end else begin
                                mem_re    = 1'b1;
                                mem_raddr = slot_last;
                                n_count   = r_count - 1'b1;
                                n_state   = S_POP;
                            end
                        end
                        KIND_SEARCH: begin
                            if (is_empty) begin
                                n_status = ST_EMPTY;
                            end else begin
                                // first read goes out now, next slot queued
                                mem_re    = 1'b1;
                                mem_raddr = r_front;
                                n_scan    = front_inc;
                                n_idx     = '0;
                                n_key     = i_data.value;
                                n_state   = S_SEARCH;
                            end
                        end
                        default: begin
                            // unused code: ignored, plain ok result
                        end
                    endcase
                end
            end
            S_POP: begin
                n_popped = mem_rdata;
                n_state  = S_DONE;
            end
            S_SEARCH: begin
                // data for entry r_idx is here; keep one read ahead
                mem_re    = 1'b1;
                mem_raddr = r_scan;
                n_scan    = scan_inc;
                if (mem_rdata == r_key) begin
                    n_status = ST_OK;
                    n_pos    = 5'(idx_inc);
                    n_state  = S_DONE;
                end else if (idx_inc == r_count) begin
                    n_status = ST_NOTFOUND;
                    n_state  = S_DONE;
                end else begin
                    n_idx = idx_inc;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid          = 1'b1;
                    n_out.status         = r_status;
                    n_out.popped_value   = r_popped;
                    n_out.found_position = r_pos;
                    n_out.occupancy      = 5'(r_count);
                    n_state              = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_front     <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_front     <= n_front;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        // payload, no reset needed
        r_idx    <= n_idx;
        r_scan   <= n_scan;
        r_key    <= n_key;
        r_status <= n_status;
        r_popped <= n_popped;
        r_pos    <= n_pos;
        r_out    <= n_out;
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

/* bench/testbench.sv */
module testbench;
    import dqvs_pkg::*;

    localparam int DEPTH = 16;

    // word extremes used by the directed part and the random value mix
    localparam logic signed [WORD_W-1:0] WORD_MIN = 32'sh8000_0000;
    localparam logic signed [WORD_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_ready;
    t_in  i_data;
    logic o_valid;
    logic i_ready;
    t_out o_data;

    deque_with_value_search_unit #(
        .DEPTH(DEPTH)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // generous limit: a slow correct run stays far below this
    initial begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // shadow copy of the deque, advanced once per accepted request item
    logic signed [WORD_W-1:0] shadow_words [DEPTH];
    int front_slot = 0;
    int word_count = 0;

    // results still owed by the block, oldest first
    t_out pending_results [$];
    int   err_count = 0;

    // while set, neither side idles
    bit   no_idle = 1'b0;
    int   ready_stall = 0;

    // next state of the deque and the result one request gives
    function automatic t_out predict_deque_result(input t_in req);
        t_out res;
        int   idx;
        res = '0;
        res.status = ST_OK;
        case (req.kind)
            KIND_PUSH_FRONT: begin
                if (word_count >= DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    front_slot = (front_slot + DEPTH - 1) % DEPTH;
                    shadow_words[front_slot] = req.value;
                    word_count++;
                end
            end
            KIND_PUSH_BACK: begin
                if (word_count >= DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    shadow_words[(front_slot + word_count) % DEPTH] = req.value;
                    word_count++;
                end
            end
            KIND_POP_FRONT: begin
                if (word_count == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    res.popped_value = shadow_words[front_slot];
                    front_slot = (front_slot + 1) % DEPTH;
                    word_count--;
                end
            end
            KIND_POP_BACK: begin
                if (word_count == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    res.popped_value = shadow_words[(front_slot + word_count - 1) % DEPTH];
                    word_count--;
                end
            end
            KIND_SEARCH: begin
                if (word_count == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    // first match from the front wins, 1-based
                    res.status = ST_NOTFOUND;
                    for (idx = 0; idx < word_count; idx++) begin
                        if (shadow_words[(front_slot + idx) % DEPTH] == req.value) begin
                            res.found_position = 5'(idx + 1);
                            res.status = ST_OK;
                            break;
                        end
                    end
                end
            end
            default: begin
                // unused codes leave the deque alone
            end
        endcase
        res.occupancy = 5'(word_count);
        return res;
    endfunction

    // one request item: random gap with valid low, then hold until taken
    task automatic send_item(input logic [2:0] kind, input logic signed [WORD_W-1:0] value);
        int   gap;
        t_in  req;
        req.kind  = kind;
        req.value = value;
        gap = no_idle ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= req;
        do @(posedge i_clk); while (!o_ready);
        pending_results.push_back(predict_deque_result(req));
        // valid stays high here; the next send or a drain decides its level
    endtask

    // sender goes quiet until every owed result has come back
    task automatic wait_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    task automatic check_field(input string name, input logic [WORD_W-1:0] want,
                               input logic [WORD_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            err_count++;
        end
    endtask

    // result side: per item stall drawn after each accepted result
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_ready && o_valid) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: result with nothing owed, expected none, actual %0h",
                             $time, o_data);
                    err_count++;
                end else begin
                    t_out want;
                    want = pending_results.pop_front();
                    check_field("status", 32'(want.status), 32'(o_data.status));
                    check_field("popped_value", want.popped_value, o_data.popped_value);
                    check_field("found_position", 32'(want.found_position),
                                32'(o_data.found_position));
                    check_field("occupancy", 32'(want.occupancy), 32'(o_data.occupancy));
                end
                ready_stall = no_idle ? 0 : $urandom_range(0, 11);
            end else if (ready_stall > 0) begin
                ready_stall--;
            end
            i_ready <= (ready_stall == 0);
        end
    end

    // small values so searches hit, plus extremes and full-width noise
    function automatic logic signed [WORD_W-1:0] random_word();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 4)
            return 32'(int'($urandom_range(0, 15)) - 8);
        else if (pick < 6)
            case ($urandom_range(0, 3))
                0: return WORD_MIN;
                1: return WORD_MAX;
                2: return '0;
                default: return -32'sd1;
            endcase
        else
            return $urandom;
    endfunction

    task automatic send_random_request(input int push_pct);
        int               pick;
        logic [2:0]       kind;
        logic signed [WORD_W-1:0] value;
        pick = $urandom_range(0, 99);
        if (pick < 2)
            kind = KIND_SEARCH + 3'($urandom_range(1, 3));
        else if (pick < push_pct)
            kind = $urandom_range(0, 1) ? KIND_PUSH_BACK : KIND_PUSH_FRONT;
        else if (pick < push_pct + 25)
            kind = KIND_SEARCH;
        else
            kind = $urandom_range(0, 1) ? KIND_POP_BACK : KIND_POP_FRONT;
        value = random_word();
        // most searches look for a word that is really stored
        if (kind == KIND_SEARCH && word_count > 0 && $urandom_range(0, 99) < 60)
            value = shadow_words[(front_slot + $urandom_range(0, word_count - 1)) % DEPTH];
        send_item(kind, value);
    endtask

    // pops and a search on the empty deque
    task automatic test_empty_requests();
        send_item(KIND_POP_FRONT, WORD_MAX);
        send_item(KIND_POP_BACK, WORD_MIN);
        send_item(KIND_SEARCH, WORD_MAX);
    endtask

    // fill from both ends, extremes first, then push into a full deque
    task automatic test_fill_to_full();
        int i;
        logic signed [WORD_W-1:0] value;
        for (i = 0; i < DEPTH; i++) begin
            case (i)
                0: value = WORD_MIN;
                1: value = WORD_MAX;
                2: value = '0;
                3: value = -32'sd1;
                default: value = 32'(i * 32'h1357_9BDF);
            endcase
            send_item(i[0] ? KIND_PUSH_BACK : KIND_PUSH_FRONT, value);
        end
        send_item(KIND_PUSH_FRONT, 32'sh0BAD_F00D);
        send_item(KIND_PUSH_BACK, 32'sh0BAD_F00D);
    endtask

    // searches at both ends and a miss on a full deque, unused codes, pops
    task automatic test_search_and_pop();
        send_item(KIND_SEARCH, shadow_words[front_slot]);
        send_item(KIND_SEARCH, shadow_words[(front_slot + word_count - 1) % DEPTH]);
        send_item(KIND_SEARCH, 32'sh5A5A_5A5A);
        send_item(KIND_SEARCH + 3'd1, WORD_MAX);
        send_item(KIND_SEARCH + 3'd2, WORD_MIN);
        send_item(KIND_SEARCH + 3'd3, -32'sd1);
        send_item(KIND_POP_FRONT, '0);
        send_item(KIND_POP_BACK, '0);
    endtask

    // phases lean toward filling, draining or a mix; some phases run without
    // gaps, and every other phase ends with the sender paused until drained
    task automatic test_random_traffic();
        int phase;
        int n;
        int push_pct;
        for (phase = 0; phase < 8; phase++) begin
            case (phase % 3)
                0: push_pct = 65;
                1: push_pct = 20;
                default: push_pct = 45;
            endcase
            no_idle = (phase == 2 || phase == 5);
            for (n = 0; n < 46; n++)
                send_random_request(push_pct);
            if (phase % 2 == 1)
                wait_drained();
        end
        no_idle = 1'b0;
    endtask

    initial begin
        i_clk   = 1'b0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_data  = '0;
        i_ready = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_requests();
        test_fill_to_full();
        test_search_and_pop();
        test_random_traffic();

        wait_drained();
        repeat (DEPTH + 4) @(posedge i_clk);
        if (err_count == 0 && pending_results.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

/* deque_with_value_search_unit.f */
rtl/dqvs_pkg.sv
rtl/dqvs_ram.sv
rtl/deque_with_value_search_unit.sv
bench/testbench.sv
